>>> hdl/wshj_pkg.sv
// ----------------------------------------------------------------------------
// wshj_pkg
// Shared types and constants of the windowed symmetric hash join.
// ----------------------------------------------------------------------------
package wshj_pkg;

	localparam int WinDepth  = 1024;
	localparam int KeyBits   = 16;
	localparam int TimeBits  = 32;
	localparam int MaxLanes  = 16;
	localparam int PtrBits   = $clog2(WinDepth);
	localparam int CntBits   = PtrBits + 1;
	localparam int KeySpace  = 1 << KeyBits;
	localparam int TotalBits = 48;
	localparam int PosBits   = 4;

	localparam logic [1:0] RegWindowLen = 2'd0;
	localparam logic [1:0] RegLaneIndex = 2'd1;
	localparam logic [1:0] RegLaneCount = 2'd2;

	localparam logic OpS = 1'b0;
	localparam logic OpR = 1'b1;

	typedef struct packed {
		logic                operation;
		logic [KeyBits-1:0]  join_key;
		logic [TimeBits-1:0] arrival_time;
	} item_in_t;

	typedef struct packed {
		logic                 processed;
		logic [10:0]          match_count;
		logic [TotalBits-1:0] running_total;
		logic                 overflow;
	} item_out_t;

	// controller to datapath
	typedef struct packed {
		logic load;       // latch input item and lane decision
		logic clr_step;   // advance clearing pass
		logic exp_rd;     // read head of opposite window
		logic exp_key_rd; // read opposite count of the head key
		logic exp_pop;    // pop head, decrement count
		logic store;      // write own window, increment own count, read probe
		logic finish;     // accumulate and present result
		logic skip;       // present skipped result
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic clr_done;
		logic take;      // tuple is processed
		logic exp_more;  // opposite window non-empty
		logic exp_old;   // head entry older than bound
	} sts_t;

endpackage

>>> hdl/wshj_ctrl.sv
// ----------------------------------------------------------------------------
// wshj_ctrl
// Sequencer: clearing pass, lane decision, expiry loop, store, probe.
// ----------------------------------------------------------------------------
module wshj_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  wshj_pkg::sts_t sts,
	output wshj_pkg::ctl_t ctl
);

	typedef enum logic [8:0] {
		ST_CLEAR = 9'b0_0000_0001,
		ST_IDLE  = 9'b0_0000_0010,
		ST_DEC   = 9'b0_0000_0100,
		ST_ERD   = 9'b0_0000_1000,
		ST_ECHK  = 9'b0_0001_0000,
		ST_EPOP  = 9'b0_0010_0000,
		ST_STORE = 9'b0_0100_0000,
		ST_PRB   = 9'b0_1000_0000,
		ST_DONE  = 9'b1_0000_0000
	} state_t;

	state_t state_q, state_d;

	// advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		busy    = 1'b1;
		case (state_q)
			ST_CLEAR: begin
				ctl.clr_step = 1'b1;
				if (sts.clr_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					ctl.load = 1'b1;
					state_d  = ST_DEC;
				end
			end
			ST_DEC: begin
				if (!sts.take) begin
					ctl.skip = 1'b1;
					state_d  = ST_IDLE;
				end else if (sts.exp_more) begin
					ctl.exp_rd = 1'b1;
					state_d    = ST_ECHK;
				end else begin
					state_d = ST_STORE;
				end
			end
			ST_ERD: begin
				if (sts.exp_more) begin
					ctl.exp_rd = 1'b1;
					state_d    = ST_ECHK;
				end else begin
					state_d = ST_STORE;
				end
			end
			ST_ECHK: begin
				if (sts.exp_old) begin
					ctl.exp_key_rd = 1'b1;
					state_d        = ST_EPOP;
				end else begin
					state_d = ST_STORE;
				end
			end
			ST_EPOP: begin
				ctl.exp_pop = 1'b1;
				state_d     = ST_ERD;
			end
			ST_STORE: begin
				ctl.store = 1'b1;
				state_d   = ST_PRB;
			end
			ST_PRB: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				ctl.finish = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && start) |=> state_q == ST_DEC)
		else $error("accepted item did not enter decision");
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.exp_pop |=> state_q == ST_ERD)
		else $error("pop not followed by head re-read");
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.exp_key_rd |=> ctl.exp_pop)
		else $error("count read not followed by pop");
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.finish, ctl.skip, ctl.load}))
		else $error("conflicting commands");

endmodule

>>> hdl/wshj_dp.sv
// ----------------------------------------------------------------------------
// wshj_dp
// Datapath: two window rings, two key count memories, totals and registers.
// ----------------------------------------------------------------------------
module wshj_dp (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [1:0]              cfg_index,
	input  logic [31:0]             cfg_data,
	input  wshj_pkg::item_in_t      item_in,
	input  wshj_pkg::ctl_t          ctl,
	output wshj_pkg::sts_t          sts,
	output logic                    done,
	output wshj_pkg::item_out_t     item_out
);

	localparam int PB = wshj_pkg::PtrBits;
	localparam int CB = wshj_pkg::CntBits;
	localparam int KB = wshj_pkg::KeyBits;
	localparam int TB = wshj_pkg::TimeBits;

	// configuration
	logic [TB-1:0] window_len_q;
	logic [3:0]    lane_index_q;
	logic [4:0]    lane_count_q;
	logic [4:0]    lanes;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q <= TB'(1024);
			lane_index_q <= '0;
			lane_count_q <= 5'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				wshj_pkg::RegWindowLen: window_len_q <= cfg_data[TB-1:0];
				wshj_pkg::RegLaneIndex: lane_index_q <= cfg_data[3:0];
				wshj_pkg::RegLaneCount: lane_count_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		lanes = lane_count_q;
		if (lanes == 5'd0) lanes = 5'd1;
		if (lanes > 5'(wshj_pkg::MaxLanes)) lanes = 5'(wshj_pkg::MaxLanes);
	end

	// latched item
	logic          op_q, take_q;
	logic [KB-1:0] key_q;
	logic [TB-1:0] time_q, bound_q;
	logic [wshj_pkg::PosBits-1:0] pos_q;
	logic [4:0]    pos_nx;

	assign pos_nx = {1'b0, pos_q} + 5'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			take_q <= 1'b0;
		end else if (ctl.load) begin
			if (item_in.operation == wshj_pkg::OpS) begin
				take_q <= ({1'b0, pos_q} == {1'b0, lane_index_q});
				pos_q  <= (pos_nx >= lanes) ? '0 : pos_nx[wshj_pkg::PosBits-1:0];
			end else begin
				take_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			op_q    <= item_in.operation;
			key_q   <= item_in.join_key;
			time_q  <= item_in.arrival_time;
			bound_q <= (item_in.arrival_time < window_len_q) ? '0
				: item_in.arrival_time - window_len_q;
		end
	end

	// window pointers, index 0 = S, 1 = R
	logic [PB-1:0] head_q [2];
	logic [CB-1:0] cnt_q  [2];
	logic          oth;
	logic [PB-1:0] slot;
	logic          own_full;

	assign oth      = ~op_q;
	assign own_full = cnt_q[op_q] == CB'(wshj_pkg::WinDepth);
	assign slot     = head_q[op_q] + cnt_q[op_q][PB-1:0];

	// window rings, key and time per entry
	logic [KB+TB-1:0] s_ring [wshj_pkg::WinDepth];
	logic [KB+TB-1:0] r_ring [wshj_pkg::WinDepth];
	logic [KB+TB-1:0] s_rd_q, r_rd_q, head_ent;

	always_ff @(posedge clk) begin
		if (ctl.store && !own_full && op_q == wshj_pkg::OpS) s_ring[slot] <= {key_q, time_q};
		if (ctl.exp_rd) s_rd_q <= s_ring[head_q[0]];
	end
	always_ff @(posedge clk) begin
		if (ctl.store && !own_full && op_q == wshj_pkg::OpR) r_ring[slot] <= {key_q, time_q};
		if (ctl.exp_rd) r_rd_q <= r_ring[head_q[1]];
	end
	assign head_ent = oth ? r_rd_q : s_rd_q;

	// key count memories; the clearing pass writes zero to every key
	logic [10:0] s_cnt [wshj_pkg::KeySpace];
	logic [10:0] r_cnt [wshj_pkg::KeySpace];
	logic [10:0] s_crd_q, r_crd_q, oth_cnt;
	logic [KB:0] clr_q;
	logic [KB-1:0] s_addr, r_addr;
	logic s_we, r_we;
	logic [10:0] s_wd, r_wd;
	logic [KB-1:0] ent_key;

	// own count for the store, read from the item's key every cycle
	logic [10:0] s_own_q, r_own_q;

	assign ent_key = head_ent[KB+TB-1:TB];
	assign oth_cnt = oth ? r_crd_q : s_crd_q;

	// pick address and write for each count memory
	always_comb begin
		s_addr = key_q; r_addr = key_q;
		s_we = 1'b0; r_we = 1'b0;
		s_wd = '0; r_wd = '0;
		if (ctl.clr_step) begin
			s_addr = clr_q[KB-1:0]; r_addr = clr_q[KB-1:0];
			s_we = 1'b1; r_we = 1'b1;
		end else if (ctl.exp_pop) begin
			if (oth == wshj_pkg::OpS) begin
				s_addr = ent_key; s_we = oth_cnt != '0; s_wd = oth_cnt - 11'd1;
			end else begin
				r_addr = ent_key; r_we = oth_cnt != '0; r_wd = oth_cnt - 11'd1;
			end
		end else if (ctl.exp_key_rd) begin
			// fetch the count of the head key ahead of the pop
			if (oth == wshj_pkg::OpS) s_addr = ent_key;
			else r_addr = ent_key;
		end else if (ctl.store && !own_full) begin
			if (op_q == wshj_pkg::OpS) begin
				s_we = 1'b1; s_wd = s_own_q + 11'd1;
			end else begin
				r_we = 1'b1; r_wd = r_own_q + 11'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_we) s_cnt[s_addr] <= s_wd;
		s_crd_q <= s_cnt[s_addr];
	end
	always_ff @(posedge clk) begin
		if (r_we) r_cnt[r_addr] <= r_wd;
		r_crd_q <= r_cnt[r_addr];
	end

	// own count follows the last read of its key
	always_ff @(posedge clk) begin
		s_own_q <= s_cnt[key_q];
		r_own_q <= r_cnt[key_q];
	end

	// clearing, lane and expiry status
	assign sts.clr_done = clr_q[KB];
	assign sts.take     = take_q;
	assign sts.exp_more = cnt_q[oth] != '0;
	assign sts.exp_old  = head_ent[TB-1:0] < bound_q;

	// pointer and clearing control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q[0] <= '0; head_q[1] <= '0;
			cnt_q[0]  <= '0; cnt_q[1]  <= '0;
			clr_q     <= '0;
		end else begin
			if (ctl.clr_step) clr_q <= clr_q + 1'b1;
			if (ctl.exp_pop) begin
				head_q[oth] <= head_q[oth] + 1'b1;
				cnt_q[oth]  <= cnt_q[oth] - 1'b1;
			end
			if (ctl.store && !own_full) cnt_q[op_q] <= cnt_q[op_q] + 1'b1;
		end
	end

	// totals and result
	logic [wshj_pkg::TotalBits-1:0] total_q;
	logic ovf_q, done_q, proc_q;
	logic [10:0] mc_q;

	always_ff @(posedge clk) begin
		if (ctl.store) ovf_q <= own_full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			done_q  <= 1'b0;
			proc_q  <= 1'b0;
			mc_q    <= '0;
		end else begin
			done_q <= ctl.finish | ctl.skip;
			if (ctl.finish) begin
				total_q <= total_q + wshj_pkg::TotalBits'(oth_cnt);
				mc_q    <= oth_cnt;
				proc_q  <= 1'b1;
			end else if (ctl.skip) begin
				mc_q   <= '0;
				proc_q <= 1'b0;
			end
		end
	end

	assign done                   = done_q;
	assign item_out.processed     = proc_q;
	assign item_out.match_count   = mc_q;
	assign item_out.running_total = total_q;
	assign item_out.overflow      = proc_q & ovf_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q[0] <= CB'(wshj_pkg::WinDepth))
		else $error("S window count beyond depth");
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.exp_pop |-> cnt_q[oth] != '0)
		else $error("pop from empty window");
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.skip |=> total_q == $past(total_q))
		else $error("skip changed total");

endmodule

>>> hdl/windowed_symmetric_hash_join.sv
// ----------------------------------------------------------------------------
// windowed_symmetric_hash_join
// Sliding-window symmetric hash join, one lane of a round-robin split.
// ----------------------------------------------------------------------------
// Usage:
//   Drive an item on item_in with start high while busy is low; it is taken
//   at that edge. One result item follows on item_out, marked by done for
//   one cycle; the receiver cannot stall it. busy falls in the cycle done is
//   high, so the next item can be taken at the edge that ends it.
//   A skipped S tuple is dropped at the lane decision and leaves both
//   windows alone. A joined tuple first expires the aged-out entries of
//   the opposite window, each by one ring read, one count read and one
//   count update, then stores itself and probes for its matches. The next
//   item is taken only after the result of the last one is given.
//   Configuration is written through cfg_we, cfg_index, cfg_data while idle.
//   After reset a clearing pass zeroes both key count memories, one key a
//   cycle, with busy high. Configuration writes are taken then.
// ----------------------------------------------------------------------------
module windowed_symmetric_hash_join (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  wshj_pkg::item_in_t  item_in,
	output logic                done,
	output wshj_pkg::item_out_t item_out,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data
);

	wshj_pkg::ctl_t ctl;
	wshj_pkg::sts_t sts;

	wshj_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.ctl    (ctl)
	);

	wshj_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item_in   (item_in),
		.ctl       (ctl),
		.sts       (sts),
		.done      (done),
		.item_out  (item_out)
	);

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// Windowed hash join testbench
// Drives S and R tuples with nondecreasing timestamps into one lane of the
// sliding-window join, predicts every result from a behavioural model of
// both windows and key count tables, and compares each result on done.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] RegUnmapped = 2'd3;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	wshj_pkg::item_in_t   item_in = '0;
	logic                 done;
	wshj_pkg::item_out_t  item_out;
	logic                 cfg_we = 1'b0;
	logic [1:0]           cfg_index = wshj_pkg::RegWindowLen;
	logic [31:0]          cfg_data = '0;

	windowed_symmetric_hash_join dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item_in(item_in),
		.done(done), .item_out(item_out), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// join model state
	logic [wshj_pkg::KeyBits-1:0]  s_keys [wshj_pkg::WinDepth];
	logic [wshj_pkg::TimeBits-1:0] s_times [wshj_pkg::WinDepth];
	logic [wshj_pkg::KeyBits-1:0]  r_keys [wshj_pkg::WinDepth];
	logic [wshj_pkg::TimeBits-1:0] r_times [wshj_pkg::WinDepth];
	int                  s_head, s_fill, r_head, r_fill;
	int                  s_per_key [int];
	int                  r_per_key [int];
	int                  s_pos;
	logic [47:0]         join_total;
	logic [31:0]         win_span = 32'd1024;
	int                  lane_idx = 0;
	int                  lane_cnt = 1;

	wshj_pkg::item_out_t expected_results [$];
	int          mismatches = 0;
	int          items_sent = 0;
	int          joined_seen = 0;
	int          send_idle_pct = 0;
	logic [31:0] s_clock = 32'd0, r_clock = 32'd0;

	// drop every opposite-window head older than the bound
	function automatic void expire_window(input logic op, input logic [31:0] now);
		logic [31:0] bound;
		int          k;
		bound = (now < win_span) ? 32'd0 : now - win_span;
		if (op == wshj_pkg::OpR) begin
			while (s_fill != 0 && s_times[s_head] < bound) begin
				k = s_keys[s_head];
				if (s_per_key.exists(k) && s_per_key[k] != 0) s_per_key[k]--;
				s_head = (s_head + 1) % wshj_pkg::WinDepth;
				s_fill--;
			end
		end else begin
			while (r_fill != 0 && r_times[r_head] < bound) begin
				k = r_keys[r_head];
				if (r_per_key.exists(k) && r_per_key[k] != 0) r_per_key[k]--;
				r_head = (r_head + 1) % wshj_pkg::WinDepth;
				r_fill--;
			end
		end
	endfunction

	function automatic wshj_pkg::item_out_t join_tuple(input wshj_pkg::item_in_t t);
		wshj_pkg::item_out_t res;
		int        lanes, slot, n;
		logic      take;
		res = '0;
		if (t.operation == wshj_pkg::OpS) begin
			lanes = (lane_cnt == 0) ? 1 :
				(lane_cnt > wshj_pkg::MaxLanes ? wshj_pkg::MaxLanes : lane_cnt);
			take = (s_pos == lane_idx);
			s_pos = (s_pos + 1 >= lanes) ? 0 : s_pos + 1;
			if (!take) begin
				res.running_total = join_total;
				return res;
			end
		end
		expire_window(t.operation, t.arrival_time);
		if (t.operation == wshj_pkg::OpR) begin
			if (r_fill >= wshj_pkg::WinDepth) res.overflow = 1'b1;
			else begin
				slot = (r_head + r_fill) % wshj_pkg::WinDepth;
				r_keys[slot] = t.join_key;
				r_times[slot] = t.arrival_time;
				r_fill++;
				r_per_key[t.join_key] = (r_per_key.exists(t.join_key) ?
					r_per_key[t.join_key] : 0) + 1;
			end
			n = s_per_key.exists(t.join_key) ? s_per_key[t.join_key] : 0;
		end else begin
			if (s_fill >= wshj_pkg::WinDepth) res.overflow = 1'b1;
			else begin
				slot = (s_head + s_fill) % wshj_pkg::WinDepth;
				s_keys[slot] = t.join_key;
				s_times[slot] = t.arrival_time;
				s_fill++;
				s_per_key[t.join_key] = (s_per_key.exists(t.join_key) ?
					s_per_key[t.join_key] : 0) + 1;
			end
			n = r_per_key.exists(t.join_key) ? r_per_key[t.join_key] : 0;
		end
		join_total = join_total + 48'(n);
		res.processed = 1'b1;
		res.match_count = 11'(n);
		res.running_total = join_total;
		return res;
	endfunction

	// send one tuple once busy is low, with a random gap first
	task automatic send_tuple(input logic op, input logic [15:0] key, input logic [31:0] t);
		wshj_pkg::item_in_t it;
		while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct)
			@(posedge clk);
		it.operation = op;
		it.join_key = key;
		it.arrival_time = t;
		start <= 1'b1;
		item_in <= it;
		@(posedge clk);
		while (busy) @(posedge clk);
		expected_results.push_back(join_tuple(it));
		items_sent++;
		start <= 1'b0;
		@(posedge clk);
	endtask

	// random tuple with timestamps advancing per stream
	task automatic send_random(input int key_range, input int max_step);
		logic op;
		op = 1'($urandom_range(1, 0));
		if (op == wshj_pkg::OpR) begin
			r_clock = r_clock + 32'($urandom_range(max_step, 0));
			send_tuple(op, 16'($urandom_range(key_range, 0)), r_clock);
		end else begin
			s_clock = s_clock + 32'($urandom_range(max_step, 0));
			send_tuple(op, 16'($urandom_range(key_range, 0)), s_clock);
		end
	endtask

	task automatic drain;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			wshj_pkg::RegWindowLen: win_span = val;
			wshj_pkg::RegLaneIndex: lane_idx = int'(val[3:0]);
			wshj_pkg::RegLaneCount: lane_cnt = int'(val[4:0]);
			default: ;
		endcase
	endtask

	// compare each result with the oldest expectation
	always @(posedge clk) begin
		wshj_pkg::item_out_t want;
		if (done) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", item_out);
			end else begin
				want = expected_results.pop_front();
				if (item_out.processed) joined_seen++;
				if (item_out !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p got %p", want, item_out);
				end
			end
		end
	end

	task automatic test_directed;
		send_tuple(wshj_pkg::OpS, 16'h0000, 32'd0);
		send_tuple(wshj_pkg::OpR, 16'h0000, 32'd0);
		send_tuple(wshj_pkg::OpR, 16'hFFFF, 32'd5);
		send_tuple(wshj_pkg::OpS, 16'hFFFF, 32'd10);
		send_tuple(wshj_pkg::OpS, 16'h0000, 32'd2000);
		send_tuple(wshj_pkg::OpR, 16'h0000, 32'd3000);
		drain();
		// lane split with index not below count: all S skipped
		write_reg(wshj_pkg::RegLaneCount, 32'd2);
		write_reg(wshj_pkg::RegLaneIndex, 32'd3);
		send_tuple(wshj_pkg::OpS, 16'h0001, 32'd3001);
		send_tuple(wshj_pkg::OpS, 16'h0001, 32'd3002);
		send_tuple(wshj_pkg::OpR, 16'h0001, 32'd3003);
		drain();
		write_reg(wshj_pkg::RegLaneCount, 32'd0);
		write_reg(wshj_pkg::RegLaneIndex, 32'd0);
		send_tuple(wshj_pkg::OpS, 16'h0002, 32'd3004);
		drain();
		write_reg(wshj_pkg::RegLaneCount, 32'd31);
		write_reg(wshj_pkg::RegLaneIndex, 32'd15);
		repeat (3) send_tuple(wshj_pkg::OpS, 16'h0002, 32'd3005);
		drain();
		write_reg(RegUnmapped, 32'hFFFF_FFFF);
		write_reg(wshj_pkg::RegLaneCount, 32'd1);
		write_reg(wshj_pkg::RegLaneIndex, 32'd0);
		s_clock = 32'd3005;
		r_clock = 32'd3005;
	endtask

	// random phases: sender idling 31 %, then 85 %, then none
	task automatic test_stream_random;
		int phase, i;
		logic [31:0] spans [3];
		spans[0] = 32'd50; spans[1] = 32'd1024; spans[2] = 32'd0;
		for (phase = 0; phase < 3; phase++) begin
			drain();
			write_reg(wshj_pkg::RegWindowLen, spans[phase]);
			write_reg(wshj_pkg::RegLaneIndex, 32'(phase));
			write_reg(wshj_pkg::RegLaneCount, 32'(phase + 1 + (phase == 2 ? 13 : 0)));
			send_idle_pct = (phase == 0) ? 31 : (phase == 1 ? 85 : 0);
			for (i = 0; i < 100; i++) begin
				send_random((i % 3 == 0) ? 65535 : 15, (i % 5 == 0) ? 3000 : 40);
				if (i == 50) drain();
			end
		end
		drain();
		send_idle_pct = 0;
	endtask

	// flush older entries from both windows at the top of time, then overflow the S window
	task automatic test_window_full;
		int i;
		write_reg(wshj_pkg::RegLaneCount, 32'd1);
		write_reg(wshj_pkg::RegLaneIndex, 32'd0);
		write_reg(wshj_pkg::RegWindowLen, 32'd0);
		send_tuple(wshj_pkg::OpR, 16'h0003, 32'hFFFF_FFFF);
		send_tuple(wshj_pkg::OpS, 16'h0003, 32'hFFFF_FFFF);
		drain();
		write_reg(wshj_pkg::RegWindowLen, 32'hFFFF_FFFF);
		for (i = 0; i < wshj_pkg::WinDepth + 4; i++)
			send_tuple(wshj_pkg::OpS, 16'(i % 4), 32'hFFFF_FFFF);
		send_tuple(wshj_pkg::OpR, 16'h0001, 32'hFFFF_FFFF);
		drain();
	endtask

	initial begin
		s_head = 0; s_fill = 0; r_head = 0; r_fill = 0;
		s_pos = 0;
		join_total = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		test_directed();
		test_stream_random();
		test_window_full();
		drain();
		$display("sent %0d tuples, %0d results joined; expiry, lane splits and a full window",
			items_sent, joined_seen);
		$display("were exercised with sender gaps of 31 %%, 85 %% and none");
		if (mismatches == 0 && expected_results.size() == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end

	initial begin
		#50ms;
		$display("== FAIL ==");
		$finish;
	end
endmodule
